// ----- hw/rtl/ucd_pkg.sv -----
// Package for the Unicode character decoder.
// Holds the transfer payload types, lane result type, mode codes and constants.
// No dependencies.
package ucd_pkg;

   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [7:0] byte3;
      logic [2:0] bytes_available;
   } req_payload_type;

   typedef struct packed {
      logic [20:0] code_point;
      logic [2:0]  bytes_consumed;
   } rsp_payload_type;

   // What one decoder lane found for the current window
   typedef struct packed {
      logic [20:0] code_point;
      logic [2:0]  bytes_consumed;
   } lane_result_type;

   localparam logic [2:0] MODE_UTF8     = 3'd0;
   localparam logic [2:0] MODE_UTF16_LE = 3'd1;
   localparam logic [2:0] MODE_UTF16_BE = 3'd2;
   localparam logic [2:0] MODE_UTF32_LE = 3'd3;
   localparam logic [2:0] MODE_UTF32_BE = 3'd4;

   localparam logic [20:0] MAX_CODE_POINT = 21'h10FFFF;
   localparam logic [20:0] FALLBACK_CHAR  = 21'h00003F;
   localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h010000;

endpackage

// ----- hw/rtl/ucd_utf8_lane.sv -----
// UTF-8 decoder lane of the Unicode character decoder.
// Depends on ucd_pkg for the lane result type and constants.
module ucd_utf8_lane (
   input  logic [7:0]                 byte0,
   input  logic [7:0]                 byte1,
   input  logic [7:0]                 byte2,
   input  logic [7:0]                 byte3,
   input  logic [2:0]                 avail,
   output ucd_pkg::lane_result_type   result
);

   logic        cont1;
   logic        cont2;
   logic        cont3;
   logic [10:0] value2;
   logic [15:0] value3;
   logic [20:0] value4;

   assign cont1 = (byte1[7:6] == 2'b10);
   assign cont2 = (byte2[7:6] == 2'b10);
   assign cont3 = (byte3[7:6] == 2'b10);

   assign value2 = {byte0[4:0], byte1[5:0]};
   assign value3 = {byte0[3:0], byte1[5:0], byte2[5:0]};
   assign value4 = {byte0[2:0], byte1[5:0], byte2[5:0], byte3[5:0]};

   always_comb begin
      // Fall back to the lead byte itself, one byte consumed
      result.code_point     = {13'd0, byte0};
      result.bytes_consumed = 3'd1;
      case (byte0) inside
         [8'hC0:8'hDF]: begin
            if (avail >= 3'd2 && cont1 && value2 >= 11'h080) begin
               result.code_point     = {10'd0, value2};
               result.bytes_consumed = 3'd2;
            end
         end
         [8'hE0:8'hEF]: begin
            if (avail >= 3'd3 && cont1 && cont2 && value3 >= 16'h0800) begin
               result.code_point     = {5'd0, value3};
               result.bytes_consumed = 3'd3;
            end
         end
         [8'hF0:8'hF7]: begin
            if (avail == 3'd4 && cont1 && cont2 && cont3 &&
                value4 >= ucd_pkg::SUPPLEMENTARY_BASE &&
                value4 <= ucd_pkg::MAX_CODE_POINT) begin
               result.code_point     = value4;
               result.bytes_consumed = 3'd4;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- hw/rtl/ucd_utf16_lane.sv -----
// UTF-16 decoder lane of the Unicode character decoder (either byte order).
// Depends on ucd_pkg for the lane result type and constants.
module ucd_utf16_lane (
   input  logic [7:0]                 byte0,
   input  logic [7:0]                 byte1,
   input  logic [7:0]                 byte2,
   input  logic [7:0]                 byte3,
   input  logic [2:0]                 avail,
   input  logic                       big_endian,
   output ucd_pkg::lane_result_type   result
);

   logic [15:0] unit_hi;
   logic [15:0] unit_lo;
   logic        is_high_surr;
   logic        is_low_surr;
   logic [20:0] pair_value;

   assign unit_hi = big_endian ? {byte0, byte1} : {byte1, byte0};
   assign unit_lo = big_endian ? {byte2, byte3} : {byte3, byte2};

   assign is_high_surr = (unit_hi[15:10] == 6'b110110);
   assign is_low_surr  = (unit_lo[15:10] == 6'b110111);
   assign pair_value   = {1'b0, unit_hi[9:0], unit_lo[9:0]} + ucd_pkg::SUPPLEMENTARY_BASE;

   always_comb begin
      if (avail < 3'd2) begin
         result.code_point     = ucd_pkg::FALLBACK_CHAR;
         result.bytes_consumed = 3'd1;
      end else if (is_high_surr && is_low_surr && avail == 3'd4) begin
         result.code_point     = pair_value;
         result.bytes_consumed = 3'd4;
      end else begin
         // Unpaired surrogates pass through too
         result.code_point     = {5'd0, unit_hi};
         result.bytes_consumed = 3'd2;
      end
   end

endmodule

// ----- hw/rtl/ucd_utf32_lane.sv -----
// UTF-32 decoder lane of the Unicode character decoder (either byte order).
// Depends on ucd_pkg for the lane result type and constants.
module ucd_utf32_lane (
   input  logic [7:0]                 byte0,
   input  logic [7:0]                 byte1,
   input  logic [7:0]                 byte2,
   input  logic [7:0]                 byte3,
   input  logic [2:0]                 avail,
   input  logic                       big_endian,
   output ucd_pkg::lane_result_type   result
);

   logic [31:0] word;

   assign word = big_endian ? {byte0, byte1, byte2, byte3} : {byte3, byte2, byte1, byte0};

   always_comb begin
      if (avail < 3'd4) begin
         result.code_point     = ucd_pkg::FALLBACK_CHAR;
         result.bytes_consumed = avail;
      end else if (word > {11'd0, ucd_pkg::MAX_CODE_POINT}) begin
         result.code_point     = ucd_pkg::FALLBACK_CHAR;
         result.bytes_consumed = 3'd4;
      end else begin
         result.code_point     = word[20:0];
         result.bytes_consumed = 3'd4;
      end
   end

endmodule

// ----- hw/rtl/unicode_char_decoder.sv -----
// Top level of the Unicode character decoder: lanes, merge and output register.
// Depends on ucd_pkg, ucd_utf8_lane, ucd_utf16_lane and ucd_utf32_lane.
//
// Decodes one character per window of up to four bytes under the encoding set in
// csr_write_data (0 UTF-8, 1 UTF-16LE, 2 UTF-16BE, 3 UTF-32LE, 4 UTF-32BE, others
// UTF-8). A window is taken every cycle while rsp_ready keeps up; its result appears
// in the cycle after the req transfer, from the output register. The UTF-8, UTF-16 and
// UTF-32 lanes decode every window side by side and the merge picks by mode, so the
// rate is set by the single output register stage. A window with bytes_available of
// zero is consumed without a result; counts above four act as four.
module unicode_char_decoder (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  ucd_pkg::req_payload_type   req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output ucd_pkg::rsp_payload_type   rsp_payload,
   input  logic                       csr_write_en,
   input  logic [2:0]                 csr_write_data
);

   logic [2:0]                 mode_ff;
   logic [2:0]                 mode_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   ucd_pkg::rsp_payload_type   rsp_payload_ff;
   ucd_pkg::rsp_payload_type   rsp_payload_in;
   logic                       req_xfer;
   logic [2:0]                 avail;
   logic                       big_endian;
   ucd_pkg::lane_result_type   utf8_result;
   ucd_pkg::lane_result_type   utf16_result;
   ucd_pkg::lane_result_type   utf32_result;
   ucd_pkg::lane_result_type   merged;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   // Clamp oversized counts to a full window
   assign avail = (req_payload.bytes_available > 3'd4) ? 3'd4 : req_payload.bytes_available;
   assign big_endian = (mode_ff == ucd_pkg::MODE_UTF16_BE) ||
                       (mode_ff == ucd_pkg::MODE_UTF32_BE);

   ucd_utf8_lane u_utf8 (
      .byte0  (req_payload.byte0),
      .byte1  (req_payload.byte1),
      .byte2  (req_payload.byte2),
      .byte3  (req_payload.byte3),
      .avail  (avail),
      .result (utf8_result)
   );

   ucd_utf16_lane u_utf16 (
      .byte0      (req_payload.byte0),
      .byte1      (req_payload.byte1),
      .byte2      (req_payload.byte2),
      .byte3      (req_payload.byte3),
      .avail      (avail),
      .big_endian (big_endian),
      .result     (utf16_result)
   );

   ucd_utf32_lane u_utf32 (
      .byte0      (req_payload.byte0),
      .byte1      (req_payload.byte1),
      .byte2      (req_payload.byte2),
      .byte3      (req_payload.byte3),
      .avail      (avail),
      .big_endian (big_endian),
      .result     (utf32_result)
   );

   always_comb begin
      case (mode_ff)
         ucd_pkg::MODE_UTF16_LE, ucd_pkg::MODE_UTF16_BE: merged = utf16_result;
         ucd_pkg::MODE_UTF32_LE, ucd_pkg::MODE_UTF32_BE: merged = utf32_result;
         default:                                        merged = utf8_result;
      endcase
   end

   always_comb begin
      mode_in = csr_write_en ? csr_write_data : mode_ff;

      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      // Empty windows are dropped without a result
      if (req_xfer && avail != 3'd0) begin
         rsp_valid_in                  = 1'b1;
         rsp_payload_in.code_point     = merged.code_point;
         rsp_payload_in.bytes_consumed = merged.bytes_consumed;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= ucd_pkg::MODE_UTF8;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   a_nonempty_gives_result : assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_payload.bytes_available != 3'd0 |=> rsp_valid)
      else $error("window transfer produced no result");

   a_empty_gives_none : assert property (@(posedge clock) disable iff (reset)
      req_xfer && req_payload.bytes_available == 3'd0 |=> !rsp_valid)
      else $error("empty window produced a result");

   a_consumed_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.bytes_consumed >= 3'd1 && rsp_payload.bytes_consumed <= 3'd4)
      else $error("bytes_consumed out of range");

   a_code_point_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.code_point <= ucd_pkg::MAX_CODE_POINT)
      else $error("code_point above the Unicode range");

   a_stall_only_when_full : assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid_ff && !rsp_ready)
      else $error("input stalled while output stage free");

endmodule
